// ===== sv/hid_report_descriptor_parser_top_assert.svh =====
// Assertion macros for the HID descriptor parser checker.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_TOP_ASSERT_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_TOP_ASSERT_SVH
// implication checked on every edge outside reset
`define HRDP_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("hrdp check failed");
// next-cycle implication
`define HRDP_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("hrdp check failed");
`endif

// ===== sv/hrdp_pkg.sv =====
package hrdp_pkg;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       last_byte;
    } hrdp_in_t;

    typedef struct packed {
        logic [15:0] page_of_usage;
        logic [15:0] usage_code;
        logic [15:0] report_number;
        logic [15:0] bit_position;
        logic [7:0]  field_bits;
        logic signed [31:0] logical_minimum;
        logic signed [31:0] logical_maximum;
        logic [31:0] main_flags;
        logic        last_field;
    } hrdp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RANGE,
        ST_READ,
        ST_EMIT,
        ST_ADV,
        ST_END
    } hrdp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic exec;
        logic range_step;
        logic rd_req;
        logic emit_next;
        logic advance;
        logic clear_all;
    } hrdp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_ready;
        logic is_input;
        logic range_fill;
        logic emit_any;
        logic emit_done;
        logic is_last;
    } hrdp_sts_t;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;
    localparam logic [1:0] TYPE_RSVD   = 2'd3;
    localparam logic [3:0] TAG_INPUT   = 4'd8;
    localparam logic [3:0] G_PAGE      = 4'd0;
    localparam logic [3:0] G_LMIN      = 4'd1;
    localparam logic [3:0] G_LMAX      = 4'd2;
    localparam logic [3:0] G_RSIZE     = 4'd7;
    localparam logic [3:0] G_RID       = 4'd8;
    localparam logic [3:0] G_RCOUNT    = 4'd9;
    localparam logic [3:0] L_USAGE     = 4'd0;
    localparam logic [3:0] L_UMIN      = 4'd1;
    localparam logic [3:0] L_UMAX      = 4'd2;

endpackage

// ===== sv/hid_report_descriptor_parser_top.sv =====
// Channel | Signals                            | Transfer when
// in      | in_valid, in_stall, in_data        | in_valid && !in_stall
// out     | out_valid, out_stall, out_data     | out_valid && !out_stall
//
// Each descriptor byte is accepted in ST_IDLE, then decoded/executed in ST_EXEC.
// An Input main item adds ST_RANGE to check for a usage range and fill slots from it,
// then ST_READ (slot memory read) and ST_EMIT (the transfer) for each field record,
// and ST_ADV for the bit advance.
// The byte marked last adds ST_END, which returns the datapath registers to reset.
// Output stalls hold the current record; no new byte is taken until it is done.
// Reset (rst_n, asynchronous) clears control and descriptor registers, not the slot memory.
module hid_report_descriptor_parser_top
    import hrdp_pkg::*;
#(
    parameter int USAGE_SLOTS = 32,
    parameter int MAX_FIELDS  = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  hrdp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output hrdp_out_t out_data
);

    hrdp_cmd_t cmd;
    hrdp_sts_t sts;

    // sequencer: byte intake, item execution and record emission steps
    hrdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // item assembly, global/local state, usage slot memory
    hrdp_datapath #(
        .USAGE_SLOTS (USAGE_SLOTS),
        .MAX_FIELDS  (MAX_FIELDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

// ===== sv/hrdp_ctrl.sv =====
module hrdp_ctrl
    import hrdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  hrdp_sts_t  sts,
    output hrdp_cmd_t  cmd
);

    hrdp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (!sts.item_ready)
                    state_next = sts.is_last ? ST_END : ST_IDLE;
                else if (sts.is_input)
                    state_next = ST_RANGE;
                else
                    state_next = sts.is_last ? ST_END : ST_IDLE;
            ST_RANGE:
                if (!sts.range_fill)
                    state_next = sts.emit_any ? ST_READ : ST_ADV;
            ST_READ:
                state_next = ST_EMIT;
            ST_EMIT:
                if (!out_stall)
                    state_next = sts.emit_done ? ST_ADV : ST_READ;
            ST_ADV:
                state_next = sts.is_last ? ST_END : ST_IDLE;
            ST_END:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take_byte = in_valid;
            end
            ST_EXEC:
                cmd.exec = sts.item_ready;
            ST_RANGE:
            begin
                cmd.range_step = sts.range_fill;
                cmd.rd_req = !sts.range_fill;
            end
            ST_READ:
                cmd.rd_req = 1'b1;
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.emit_next = !out_stall;
            end
            ST_ADV:
                cmd.advance = 1'b1;
            ST_END:
                cmd.clear_all = 1'b1;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== sv/hrdp_datapath.sv =====
module hrdp_datapath
    import hrdp_pkg::*;
#(
    parameter int USAGE_SLOTS = 32,
    parameter int MAX_FIELDS  = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  hrdp_in_t   in_data,
    input  hrdp_cmd_t  cmd,
    output hrdp_sts_t  sts,
    output hrdp_out_t  out_data
);

    localparam int SW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
    localparam int CW = $clog2(USAGE_SLOTS + 1);
    localparam int EW = $clog2(MAX_FIELDS + 1);

    logic [15:0] slots [USAGE_SLOTS];

    logic [2:0]  left_reg;
    logic [1:0]  idx_reg;
    logic [7:0]  prefix_reg;
    logic [31:0] value_reg;
    logic        ready_reg, last_reg;
    logic [15:0] page_reg, rid_reg, bitpos_reg;
    logic [31:0] lmin_reg, lmax_reg, rcount_reg;
    logic [7:0]  rsize_reg;
    logic [CW-1:0] cnt_reg;
    logic [15:0] rmin_reg, rmax_reg, rcur_reg;
    logic        rpres_reg, rdone_reg;
    logic [EW-1:0] emit_reg, ei_reg;
    logic [15:0] epos_reg;
    logic [15:0] rd_reg;
    logic [CW-1:0] ridx;

    logic [1:0] psz;
    logic [2:0] bsz;
    logic [1:0] ptype;
    logic [3:0] ptag;
    logic [31:0] sval;
    logic [15:0] adv;

    assign psz   = prefix_reg[1:0];
    assign ptype = prefix_reg[3:2];
    assign ptag  = prefix_reg[7:4];
    assign bsz   = (in_data.desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, in_data.desc_byte[1:0]};
    assign adv   = rcount_reg[15:0] * {8'd0, rsize_reg};

    always_comb
    begin
        sval = value_reg;
        if (psz == 2'd1 && value_reg[7])
            sval = value_reg | 32'hFFFF_FF00;
        else if (psz == 2'd2 && value_reg[15])
            sval = value_reg | 32'hFFFF_0000;
    end

    // slot index for the next record read
    always_comb
    begin
        if ({{(32-EW){1'b0}}, ei_reg} < {{(32-CW){1'b0}}, cnt_reg})
            ridx = CW'(ei_reg);
        else
            ridx = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && ptype == TYPE_LOCAL && ptag == L_USAGE
            && cnt_reg < CW'(USAGE_SLOTS))
            slots[cnt_reg[SW-1:0]] <= value_reg[15:0];
        else if (cmd.range_step)
            slots[cnt_reg[SW-1:0]] <= rcur_reg;
        if (cmd.rd_req)
            rd_reg <= slots[ridx[SW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0; idx_reg <= '0; prefix_reg <= '0; value_reg <= '0;
            ready_reg <= 1'b0; last_reg <= 1'b0;
            page_reg <= '0; rid_reg <= 16'hFFFF; bitpos_reg <= '0;
            lmin_reg <= '0; lmax_reg <= '0; rcount_reg <= '0; rsize_reg <= '0;
            cnt_reg <= '0; rmin_reg <= '0; rmax_reg <= '0; rcur_reg <= '0;
            rpres_reg <= 1'b0; rdone_reg <= 1'b0;
            emit_reg <= '0; ei_reg <= '0; epos_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            left_reg <= '0; idx_reg <= '0; prefix_reg <= '0; value_reg <= '0;
            ready_reg <= 1'b0; last_reg <= 1'b0;
            page_reg <= '0; rid_reg <= 16'hFFFF; bitpos_reg <= '0;
            lmin_reg <= '0; lmax_reg <= '0; rcount_reg <= '0; rsize_reg <= '0;
            cnt_reg <= '0; rmin_reg <= '0; rmax_reg <= '0; rcur_reg <= '0;
            rpres_reg <= 1'b0; rdone_reg <= 1'b0;
            emit_reg <= '0; ei_reg <= '0; epos_reg <= '0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                last_reg <= in_data.last_byte;
                if (left_reg == 3'd0)
                begin
                    prefix_reg <= in_data.desc_byte;
                    value_reg <= '0;
                    idx_reg <= '0;
                    left_reg <= bsz;
                    ready_reg <= (bsz == 3'd0);
                end
                else
                begin
                    value_reg <= value_reg | ({24'd0, in_data.desc_byte} << {idx_reg, 3'b000});
                    idx_reg <= idx_reg + 2'd1;
                    left_reg <= left_reg - 3'd1;
                    ready_reg <= (left_reg == 3'd1);
                end
            end
            if (cmd.exec)
            begin
                case (ptype)
                    TYPE_GLOBAL:
                        case (ptag)
                            G_PAGE:   page_reg <= value_reg[15:0];
                            G_LMIN:   lmin_reg <= sval;
                            G_LMAX:   lmax_reg <= sval;
                            G_RSIZE:  rsize_reg <= (value_reg > 32'd255) ? 8'd255
                                                                           : value_reg[7:0];
                            G_RID:
                            begin
                                rid_reg <= value_reg[15:0];
                                bitpos_reg <= '0;
                            end
                            G_RCOUNT: rcount_reg <= value_reg;
                            default:  rid_reg <= rid_reg;
                        endcase
                    TYPE_LOCAL:
                        case (ptag)
                            L_USAGE:
                                if (cnt_reg < CW'(USAGE_SLOTS))
                                    cnt_reg <= cnt_reg + CW'(1);
                            L_UMIN:
                            begin
                                rmin_reg <= value_reg[15:0];
                                rpres_reg <= 1'b1;
                            end
                            L_UMAX:   rmax_reg <= value_reg[15:0];
                            default:  rmax_reg <= rmax_reg;
                        endcase
                    TYPE_MAIN:
                    begin
                        rcur_reg <= rmin_reg;
                        rdone_reg <= (cnt_reg != '0) || !rpres_reg
                                     || (rmin_reg > rmax_reg);
                        if (!value_reg[0])
                            emit_reg <= (rcount_reg < 32'(MAX_FIELDS)) ? EW'(rcount_reg)
                                                                       : EW'(MAX_FIELDS);
                        else
                            emit_reg <= '0;
                        ei_reg <= '0;
                        epos_reg <= bitpos_reg;
                        if (ptag != TAG_INPUT)
                        begin
                            cnt_reg <= '0; rpres_reg <= 1'b0;
                            rmin_reg <= '0; rmax_reg <= '0;
                        end
                    end
                    default: ;
                endcase
                ready_reg <= 1'b0;
            end
            if (cmd.range_step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                rcur_reg <= rcur_reg + 16'd1;
                if (rcur_reg == rmax_reg || cnt_reg == CW'(USAGE_SLOTS - 1))
                    rdone_reg <= 1'b1;
            end
            if (cmd.emit_next)
            begin
                ei_reg <= ei_reg + EW'(1);
                epos_reg <= epos_reg + {8'd0, rsize_reg};
            end
            if (cmd.advance)
            begin
                bitpos_reg <= bitpos_reg + adv;
                cnt_reg <= '0; rpres_reg <= 1'b0;
                rmin_reg <= '0; rmax_reg <= '0;
            end
        end
    end

    assign sts.item_ready = ready_reg;
    assign sts.is_input   = (ptype == TYPE_MAIN) && (ptag == TAG_INPUT);
    assign sts.range_fill = !rdone_reg;
    assign sts.emit_any   = (emit_reg != '0);
    assign sts.emit_done  = (ei_reg + EW'(1) == emit_reg);
    assign sts.is_last    = last_reg;

    assign out_data.page_of_usage   = page_reg;
    assign out_data.usage_code      = (cnt_reg == '0) ? 16'd0 : rd_reg;
    assign out_data.report_number   = rid_reg;
    assign out_data.bit_position    = epos_reg;
    assign out_data.field_bits      = rsize_reg;
    assign out_data.logical_minimum = lmin_reg;
    assign out_data.logical_maximum = lmax_reg;
    assign out_data.main_flags      = value_reg;
    assign out_data.last_field      = (ei_reg + EW'(1) == emit_reg);

endmodule

// ===== sv/hrdp_checker.sv =====
module hrdp_checker
    import hrdp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input hrdp_in_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input hrdp_out_t out_data
);
`include "hid_report_descriptor_parser_top_assert.svh"

    `HRDP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `HRDP_ASSERT_IMP(a_no_take_while_out, out_valid, in_stall)
    `HRDP_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind hid_report_descriptor_parser_top hrdp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/hid_report_descriptor_parser_top_tb.sv =====
module hid_report_descriptor_parser_top_tb;
    import hrdp_pkg::*;

    localparam int SLOT_DEPTH = 32;
    localparam int FIELD_CAP  = 64;

    // ------------------------------------------------------------------
    // Scoreboard: holds the parser state as predicted from the byte stream
    // and the queue of field records still owed by the block.
    // ------------------------------------------------------------------
    class hrdp_scoreboard;
        hrdp_out_t   pending_fields[$];
        int          errors;
        int          fields_seen;
        int          bytes_seen;
        int          truncations;

        // predicted parser state
        int unsigned bytes_left;
        logic [7:0]  prefix;
        logic [31:0] value;
        logic [15:0] page;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [7:0]  rsize;
        logic [31:0] rcount;
        logic [15:0] rid;
        logic [15:0] bitpos;
        logic [15:0] slots[SLOT_DEPTH];
        int unsigned slot_count;
        logic [15:0] umin;
        logic [15:0] umax;
        logic        range_on;

        function new();
            errors      = 0;
            fields_seen = 0;
            bytes_seen  = 0;
            truncations = 0;
            clear_state();
        endfunction

        function void clear_locals();
            slot_count = 0;
            range_on   = 1'b0;
            umin       = '0;
            umax       = '0;
        endfunction

        function void clear_state();
            bytes_left = 0;
            prefix     = '0;
            value      = '0;
            page       = '0;
            lmin       = '0;
            lmax       = '0;
            rsize      = '0;
            rcount     = '0;
            rid        = 16'hFFFF;
            bitpos     = '0;
            for (int k = 0; k < SLOT_DEPTH; k++)
                slots[k] = '0;
            clear_locals();
        endfunction

        function int unsigned size_of(logic [7:0] p);
            return (p[1:0] == 2'd3) ? 4 : p[1:0];
        endfunction

        // Input main item: expand the range if needed, queue the records, advance the bit position
        function void expand_input(logic [31:0] flags);
            int unsigned n;
            int unsigned u;
            hrdp_out_t   rec;
            logic [63:0] adv;
            if (range_on && slot_count == 0)
            begin
                u = umin;
                while (u <= umax && slot_count < SLOT_DEPTH)
                begin
                    slots[slot_count] = u[15:0];
                    slot_count++;
                    u++;
                end
            end
            n = 0;
            if (!flags[0])
                n = (rcount < FIELD_CAP) ? rcount : FIELD_CAP;
            for (int unsigned i = 0; i < n; i++)
            begin
                rec.page_of_usage   = page;
                if (i < slot_count)
                    rec.usage_code = slots[i];
                else if (slot_count > 0)
                    rec.usage_code = slots[slot_count - 1];
                else
                    rec.usage_code = '0;
                rec.report_number   = rid;
                rec.bit_position    = bitpos + 16'(i * rsize);
                rec.field_bits      = rsize;
                rec.logical_minimum = lmin;
                rec.logical_maximum = lmax;
                rec.main_flags      = flags;
                rec.last_field      = (i + 1 == n);
                pending_fields.push_back(rec);
            end
            adv    = 64'(rcount) * 64'(rsize);
            bitpos = bitpos + adv[15:0];
        endfunction

        function void run_item();
            logic [1:0]  typ;
            logic [3:0]  tag;
            logic [31:0] sv;
            typ = prefix[3:2];
            tag = prefix[7:4];
            sv  = value;
            if (size_of(prefix) == 1 && value[7])
                sv = value | 32'hFFFFFF00;
            else if (size_of(prefix) == 2 && value[15])
                sv = value | 32'hFFFF0000;
            if (typ == TYPE_GLOBAL)
            begin
                case (tag)
                    G_PAGE:   page  = value[15:0];
                    G_LMIN:   lmin  = sv;
                    G_LMAX:   lmax  = sv;
                    G_RSIZE:  rsize = (value > 255) ? 8'd255 : value[7:0];
                    G_RID:
                    begin
                        rid    = value[15:0];
                        bitpos = '0;
                    end
                    G_RCOUNT: rcount = value;
                    default: ;
                endcase
            end
            else if (typ == TYPE_LOCAL)
            begin
                case (tag)
                    L_USAGE:
                        if (slot_count < SLOT_DEPTH)
                        begin
                            slots[slot_count] = value[15:0];
                            slot_count++;
                        end
                    L_UMIN:
                    begin
                        umin     = value[15:0];
                        range_on = 1'b1;
                    end
                    L_UMAX: umax = value[15:0];
                    default: ;
                endcase
            end
            else if (typ == TYPE_MAIN)
            begin
                if (tag == TAG_INPUT)
                    expand_input(value);
                clear_locals();
            end
        endfunction

        // note one accepted descriptor byte
        function void note_byte(hrdp_in_t b);
            logic ready;
            int unsigned idx;
            ready = 1'b0;
            bytes_seen++;
            if (bytes_left == 0)
            begin
                prefix     = b.desc_byte;
                value      = '0;
                bytes_left = size_of(b.desc_byte);
                ready      = (bytes_left == 0);
            end
            else
            begin
                idx = (size_of(prefix) - bytes_left) & 3;
                value = value | (32'(b.desc_byte) << (8 * idx));
                bytes_left--;
                ready = (bytes_left == 0);
            end
            if (ready)
                run_item();
            else if (b.last_byte)
                truncations++;
            if (b.last_byte)
                clear_state();
        endfunction

        function void check_field(hrdp_out_t got);
            hrdp_out_t want;
            fields_seen++;
            if (pending_fields.size() == 0)
            begin
                $error("unexpected field record: %p", got);
                errors++;
                return;
            end
            want = pending_fields.pop_front();
            if (got.page_of_usage !== want.page_of_usage)
            begin
                $error("page_of_usage: expected %h, got %h",
                    want.page_of_usage, got.page_of_usage);
                errors++;
            end
            if (got.usage_code !== want.usage_code)
            begin
                $error("usage_code: expected %h, got %h", want.usage_code, got.usage_code);
                errors++;
            end
            if (got.report_number !== want.report_number)
            begin
                $error("report_number: expected %h, got %h",
                    want.report_number, got.report_number);
                errors++;
            end
            if (got.bit_position !== want.bit_position)
            begin
                $error("bit_position: expected %h, got %h",
                    want.bit_position, got.bit_position);
                errors++;
            end
            if (got.field_bits !== want.field_bits)
            begin
                $error("field_bits: expected %h, got %h", want.field_bits, got.field_bits);
                errors++;
            end
            if (got.logical_minimum !== want.logical_minimum)
            begin
                $error("logical_minimum: expected %h, got %h",
                    want.logical_minimum, got.logical_minimum);
                errors++;
            end
            if (got.logical_maximum !== want.logical_maximum)
            begin
                $error("logical_maximum: expected %h, got %h",
                    want.logical_maximum, got.logical_maximum);
                errors++;
            end
            if (got.main_flags !== want.main_flags)
            begin
                $error("main_flags: expected %h, got %h",
                    want.main_flags, got.main_flags);
                errors++;
            end
            if (got.last_field !== want.last_field)
            begin
                $error("last_field: expected %b, got %b", want.last_field, got.last_field);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    hrdp_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    hrdp_out_t out_data;

    hrdp_scoreboard board;
    hrdp_in_t       desc_bytes[$];   // bytes waiting to be sent

    hid_report_descriptor_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, well beyond the slowest legal run (every byte with its input gap,
    // plus 64 records per Input, each held off by the receiver).
    initial
    begin
        #8000000;
        $display("** hid_report_descriptor_parser_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Descriptor building helpers: append one short item
    // ------------------------------------------------------------------
    task automatic put_item(input logic [1:0] typ, input logic [3:0] tag,
                            input logic [1:0] szc, input logic [31:0] val);
        int unsigned n;
        hrdp_in_t b;
        n = (szc == 2'd3) ? 4 : szc;
        b.last_byte = 1'b0;
        b.desc_byte = {tag, typ, szc};
        desc_bytes.push_back(b);
        for (int unsigned k = 0; k < n; k++)
        begin
            b.desc_byte = val[8 * k +: 8];
            desc_bytes.push_back(b);
        end
    endtask

    // mark the most recently queued byte as the end of the descriptor
    task automatic end_descriptor();
        hrdp_in_t b;
        b = desc_bytes.pop_back();
        b.last_byte = 1'b1;
        desc_bytes.push_back(b);
    endtask

    function automatic logic [1:0] rand_size();
        return 2'($urandom_range(0, 3));
    endfunction

    // A descriptor with random content: globals, locals, Inputs, other items, sometimes cut short
    task automatic build_descriptor();
        int unsigned items;
        int unsigned pick;
        items = $urandom_range(3, 12);
        for (int unsigned k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0: put_item(TYPE_GLOBAL, G_PAGE, rand_size(), $urandom);
                1: put_item(TYPE_GLOBAL, G_LMIN, rand_size(), $urandom);
                2: put_item(TYPE_GLOBAL, G_LMAX, rand_size(), $urandom);
                3: put_item(TYPE_GLOBAL, G_RSIZE, 2'd1,
                       ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32));
                4: put_item(TYPE_GLOBAL, G_RID, rand_size(), $urandom);
                5: put_item(TYPE_GLOBAL, G_RCOUNT, 2'd1,
                       ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6));
                6, 7: put_item(TYPE_LOCAL, L_USAGE, rand_size(), $urandom);
                8:
                begin
                    put_item(TYPE_LOCAL, L_UMIN, 2'd2, $urandom_range(0, 65535));
                    put_item(TYPE_LOCAL, L_UMAX, 2'd2, $urandom_range(0, 65535));
                end
                9, 10, 11: put_item(TYPE_MAIN, TAG_INPUT, rand_size(),
                       $urandom & ~32'($urandom_range(0, 3) != 0));
                12: put_item(TYPE_MAIN, 4'($urandom_range(9, 15)), rand_size(), $urandom);
                13: put_item(TYPE_RSVD, 4'($urandom), rand_size(), $urandom);
                default: put_item(2'($urandom_range(1, 2)), 4'($urandom_range(3, 15)),
                       rand_size(), $urandom);
            endcase
        end
        // occasionally chop the tail so the last byte cuts an item short
        if ($urandom_range(0, 5) == 0)
            put_item(TYPE_GLOBAL, G_PAGE, 2'd3, $urandom);
        if ($urandom_range(0, 5) == 0 && desc_bytes.size() > 1)
            void'(desc_bytes.pop_back());
        end_descriptor();
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_bytes();
        int unsigned gap;
        hrdp_in_t b;
        while (desc_bytes.size() > 0)
        begin
            b   = desc_bytes.pop_front();
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            board.note_byte(b);
        end
        in_valid <= 1'b0;
    endtask

    // Receiver stall pattern: random hold-off per record, with calm stretches
    initial
    begin
        int unsigned hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Monitor: a transfer happens at an edge where valid && !stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_field(out_data);
    end

    initial
    begin
        int unsigned wait_cycles;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, sign extension, saturation, long count, range
        put_item(TYPE_GLOBAL, G_PAGE, 2'd2, 32'h0000FFFF);
        put_item(TYPE_GLOBAL, G_LMIN, 2'd1, 32'h00000080);
        put_item(TYPE_GLOBAL, G_LMAX, 2'd2, 32'h00007FFF);
        put_item(TYPE_GLOBAL, G_RSIZE, 2'd2, 32'h00000300);
        put_item(TYPE_GLOBAL, G_RCOUNT, 2'd1, 32'h00000003);
        put_item(TYPE_LOCAL, L_USAGE, 2'd2, 32'h0000FFFF);
        put_item(TYPE_MAIN, TAG_INPUT, 2'd1, 32'h00000002);
        put_item(TYPE_MAIN, TAG_INPUT, 2'd1, 32'h00000001);
        put_item(TYPE_GLOBAL, G_RID, 2'd3, 32'hFFFFFFFF);
        put_item(TYPE_GLOBAL, G_LMIN, 2'd3, 32'h80000000);
        put_item(TYPE_GLOBAL, G_RCOUNT, 2'd3, 32'hFFFFFFFF);
        put_item(TYPE_LOCAL, L_UMIN, 2'd1, 32'h00000010);
        put_item(TYPE_LOCAL, L_UMAX, 2'd2, 32'h0000FFFF);
        put_item(TYPE_MAIN, TAG_INPUT, 2'd0, 32'h0);
        put_item(TYPE_MAIN, 4'hC, 2'd0, 32'h0);
        put_item(TYPE_RSVD, 4'hF, 2'd1, 32'h000000FF);
        put_item(TYPE_GLOBAL, G_PAGE, 2'd3, 32'h0);
        void'(desc_bytes.pop_back());
        end_descriptor();
        send_bytes();

        // Random descriptors until at least 250 bytes have been sent in all
        while (board.bytes_seen < 250)
        begin
            build_descriptor();
            send_bytes();
        end

        wait_cycles = 0;
        while (board.pending_fields.size() > 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);

        $display("Covered %0d descriptor bytes, %0d field records, %0d truncated items.",
            board.bytes_seen, board.fields_seen, board.truncations);
        if (board.errors == 0 && board.pending_fields.size() == 0)
            $display("** hid_report_descriptor_parser_top: PASSED **");
        else
        begin
            if (board.pending_fields.size() > 0)
                $error("%0d field records never arrived", board.pending_fields.size());
            $display("** hid_report_descriptor_parser_top: FAILED **");
        end
        $finish;
    end
endmodule
